@@ src/phr_pkg.sv @@
// Shared constants, types and command struct for the PC history ring.
`timescale 1ns / 1ps
package phr_pkg;

    // Ring capacity in recorded PCs; the ring has one spare slot.
    localparam int HIST_DEPTH = 256;
    localparam int RING_SLOTS = HIST_DEPTH + 1;
    localparam int PTR_W      = $clog2(RING_SLOTS);

    // Field widths of one transaction.
    localparam int FUNC_W = 2;
    localparam int PC_W   = 32;
    localparam int BACK_W = 8;

    // Width wide enough to compare an offset with the fill count.
    localparam int CMP_W = ((PTR_W > BACK_W) ? PTR_W : BACK_W) + 1;

    // Function codes.
    localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef logic [PTR_W-1:0] t_ptr;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic record;   // write pc at the write pointer and advance
        logic clear;    // empty the ring
        logic lookup;   // work out the slot and hit flag of a read
        logic fetch;    // read the ring memory at the looked-up slot
        logic emit;     // drive the result for one cycle
    } t_dp_cmd;

endpackage

@@ src/pc_history_ring_core.sv @@
// Top level of the PC history ring: controller plus datapath.
//
//  channel  | handshake                 | fields
//  ---------+---------------------------+------------------------------------
//  command  | start in, busy out        | i_func, i_pc_value, i_back_offset
//  result   | o_done out (one cycle)    | o_history_pc, o_present
//
// Record and clear need no busy state; busy stays low and the next transaction
// is taken on the following edge. A read passes through lookup, ring
// memory fetch (registered read port), then o_done for one cycle.
// Reset is synchronous and active low; it empties the ring at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module pc_history_ring_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [phr_pkg::FUNC_W-1:0]  i_func,
    input  logic [phr_pkg::PC_W-1:0]    i_pc_value,
    input  logic [phr_pkg::BACK_W-1:0]  i_back_offset,
    output logic                        o_done,
    output logic [phr_pkg::PC_W-1:0]    o_history_pc,
    output logic                        o_present
);

    phr_pkg::t_dp_cmd w_cmd;

    phr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    phr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_pc_value    (i_pc_value),
        .i_back_offset (i_back_offset),
        .o_history_pc  (o_history_pc),
        .o_present     (o_present)
    );

    assign o_done = w_cmd.emit;

`ifndef ASSERT_OFF
    // A read transaction makes the block busy on the next cycle.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == phr_pkg::FUNC_READ) |=> busy)
        else $error("read transaction did not raise busy");

    // Record, clear and unused codes give no result and leave the block idle.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != phr_pkg::FUNC_READ) |=> (!busy && !o_done))
        else $error("non-read transaction produced a result or held busy");

    // A result ends the read; the block is free on the next cycle.
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("result repeated or busy held after result");

    // The result comes in the show state, straight after the fetch state that follows the taken read.
    a_done_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == phr_pkg::FUNC_READ) |=> ##1 o_done)
        else $error("read result not delivered on time");
`endif

endmodule

@@ src/phr_ctrl.sv @@
// Controller state machine for the PC history ring.
`timescale 1ns / 1ps
module phr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [phr_pkg::FUNC_W-1:0]  i_func,
    output logic                        busy,
    output phr_pkg::t_dp_cmd            o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SHOW  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // Decode the transaction and sequence a read through fetch and show.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        phr_pkg::FUNC_RECORD: o_cmd.record = 1'b1;
                        phr_pkg::FUNC_CLEAR:  o_cmd.clear  = 1'b1;
                        phr_pkg::FUNC_READ: begin
                            o_cmd.lookup = 1'b1;
                            n_state      = ST_FETCH;
                        end
                        default: ;  // unused code: drop it
                    endcase
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_SHOW;
            end
            ST_SHOW: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/phr_datapath.sv @@
// Datapath of the PC history ring: pointers, fill count and ring memory.
`timescale 1ns / 1ps
module phr_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  phr_pkg::t_dp_cmd            i_cmd,
    input  logic [phr_pkg::PC_W-1:0]    i_pc_value,
    input  logic [phr_pkg::BACK_W-1:0]  i_back_offset,
    output logic [phr_pkg::PC_W-1:0]    o_history_pc,
    output logic                        o_present
);

    localparam logic [phr_pkg::PTR_W-1:0] LAST_PTR  = phr_pkg::PTR_W'(phr_pkg::HIST_DEPTH);
    localparam logic [phr_pkg::CMP_W-1:0] SLOTS_EXT = phr_pkg::CMP_W'(phr_pkg::RING_SLOTS);

    logic [phr_pkg::PC_W-1:0] r_mem [phr_pkg::RING_SLOTS];

    phr_pkg::t_ptr             r_wr_ptr;
    phr_pkg::t_ptr             r_count;
    phr_pkg::t_ptr             r_slot;
    logic                      r_hit;
    logic [phr_pkg::PC_W-1:0]  r_rd_data;

    logic [phr_pkg::CMP_W-1:0] w_back_ext;
    logic [phr_pkg::CMP_W-1:0] w_step;
    logic [phr_pkg::CMP_W-1:0] w_wp_ext;
    logic [phr_pkg::CMP_W-1:0] w_slot_ext;
    logic                      w_hit;

    // Locate the entry the offset names, wrapping below slot zero.
    assign w_back_ext = phr_pkg::CMP_W'(i_back_offset);
    assign w_step     = w_back_ext + phr_pkg::CMP_W'(1);
    assign w_wp_ext   = phr_pkg::CMP_W'(r_wr_ptr);
    assign w_hit      = w_back_ext < phr_pkg::CMP_W'(r_count);
    assign w_slot_ext = (w_wp_ext >= w_step) ? (w_wp_ext - w_step)
                                             : (w_wp_ext + SLOTS_EXT - w_step);

    // Advance the write pointer and fill count; clear empties the ring.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else if (i_cmd.clear) begin
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else if (i_cmd.record) begin
            r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + phr_pkg::PTR_W'(1);
            if (r_count != LAST_PTR) begin
                r_count <= r_count + phr_pkg::PTR_W'(1);
            end
        end
    end

    // Hold the looked-up slot and hit flag for the fetch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_slot <= w_slot_ext[phr_pkg::PTR_W-1:0];
            r_hit  <= w_hit;
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            r_mem[r_wr_ptr] <= i_pc_value;
        end
        if (i_cmd.fetch) begin
            r_rd_data <= r_mem[r_slot];
        end
    end

    // Drive the result only in its cycle; a miss reads as zero.
    assign o_present    = i_cmd.emit && r_hit;
    assign o_history_pc = o_present ? r_rd_data : '0;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the PC history ring: directed table, then random traffic.
`timescale 1ns / 1ps
module tb;
    import phr_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int WD_LIMIT  = 2000;
    localparam int RAND_TXNS = 2000;
    localparam int DIR_ROWS  = 23;
    localparam int DRAIN_CYC = 8;

    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic            present;
    } t_hist_res;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PC_W-1:0]   pc;
        logic [BACK_W-1:0] back;
        logic              typed;
        logic [PC_W-1:0]   exp_pc;
        logic              exp_present;
    } t_dir_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic [FUNC_W-1:0] i_func        = '0;
    logic [PC_W-1:0]   i_pc_value    = '0;
    logic [BACK_W-1:0] i_back_offset = '0;
    logic              busy;
    logic              o_done;
    logic [PC_W-1:0]   o_history_pc;
    logic              o_present;

    // Shadow copy of the trace ring
    logic [PC_W-1:0] shadow_pc [RING_SLOTS];
    int              wr_slot  = 0;
    int              old_slot = 0;

    t_hist_res pending_reads [$];
    t_dir_row  dir_tbl [DIR_ROWS];

    int  n_errors   = 0;
    int  n_record   = 0;
    int  n_lookup   = 0;
    int  n_clear    = 0;
    int  n_ignored  = 0;
    int  n_hits     = 0;
    int  n_misses   = 0;
    int  n_full_rd  = 0;
    int  peak_fill  = 0;
    int  idle_count = 0;
    bit  no_gaps    = 1'b0;

    pc_history_ring_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_pc_value    (i_pc_value),
        .i_back_offset (i_back_offset),
        .o_done        (o_done),
        .o_history_pc  (o_history_pc),
        .o_present     (o_present)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Number of PCs currently held in the shadow ring
    function automatic int fill_level();
        return (wr_slot >= old_slot) ? (wr_slot - old_slot) : (wr_slot + RING_SLOTS - old_slot);
    endfunction

    // Apply one transaction to the shadow ring; return 1 when it yields a result
    function automatic bit ring_step(input logic [FUNC_W-1:0] f, input logic [PC_W-1:0] pc,
                                     input logic [BACK_W-1:0] back, output t_hist_res res);
        int held;
        int back_span;
        int slot;
        res = '0;
        case (f)
            FUNC_RECORD: begin
                shadow_pc[wr_slot] = pc;
                wr_slot = (wr_slot == HIST_DEPTH) ? 0 : wr_slot + 1;
                // drop the oldest entry once the ring wraps onto it
                if (wr_slot == old_slot)
                    old_slot = (old_slot == HIST_DEPTH) ? 0 : old_slot + 1;
                return 1'b0;
            end
            FUNC_READ: begin
                held = fill_level();
                if (int'(back) < held) begin
                    back_span = int'(back) + 1;
                    slot = (wr_slot >= back_span) ? (wr_slot - back_span)
                                                  : (wr_slot + RING_SLOTS - back_span);
                    res.pc      = shadow_pc[slot];
                    res.present = 1'b1;
                end
                return 1'b1;
            end
            FUNC_CLEAR: begin
                wr_slot  = 0;
                old_slot = 0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Drive one transaction after a random gap (none while no_gaps is set) and wait for it to be taken
    task automatic send_txn(input logic [FUNC_W-1:0] f, input logic [PC_W-1:0] pc,
                            input logic [BACK_W-1:0] back, input bit typed,
                            input t_hist_res typed_res);
        int        gap;
        int        held;
        bit        has_res;
        t_hist_res res;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= f;
        i_pc_value    <= pc;
        i_back_offset <= back;
        do @(posedge i_clk); while (busy);
        held = fill_level();
        if (f == FUNC_READ && held == HIST_DEPTH)
            n_full_rd++;
        has_res = ring_step(f, pc, back, res);
        if (has_res)
            pending_reads.push_back(typed ? typed_res : res);
        case (f)
            FUNC_RECORD: n_record++;
            FUNC_READ:   n_lookup++;
            FUNC_CLEAR:  n_clear++;
            default:     n_ignored++;
        endcase
        if (fill_level() > peak_fill)
            peak_fill = fill_level();
    endtask

    // Check each strobed result against the oldest pending expectation
    always @(posedge i_clk) begin
        t_hist_res exp_res;
        if (i_rst_n && o_done) begin
            if (pending_reads.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result pc=%h present=%b", $time,
                         o_history_pc, o_present);
            end else begin
                exp_res = pending_reads.pop_front();
                if (o_present) n_hits++; else n_misses++;
                if (o_history_pc !== exp_res.pc) begin
                    n_errors++;
                    $display("%0t: history_pc expected %h actual %h", $time,
                             exp_res.pc, o_history_pc);
                end
                if (o_present !== exp_res.present) begin
                    n_errors++;
                    $display("%0t: present expected %b actual %b", $time,
                             exp_res.present, o_present);
                end
            end
        end
    end

    // Abort when neither side moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_count <= 0;
        end else if (idle_count >= WD_LIMIT) begin
            $display("%0t: watchdog expired, %0d results pending", $time, pending_reads.size());
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        t_hist_res         tres;
        logic [FUNC_W-1:0] f;
        logic [BACK_W-1:0] back;
        int                r;
        int                ofs;
        int                held;
        int                fill_run;

        // Directed cases: empty reads, extremes, offset at the fill count, unused code, clear
        dir_tbl = '{
            '{FUNC_READ,   32'h0000_0000, 8'd0,   1'b1, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'h0000_0000, 8'd255, 1'b1, 32'h0000_0000, 1'b0},
            '{FUNC_RECORD, 32'hFFFF_FFFF, 8'd0,   1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_RECORD, 32'h0000_0000, 8'd255, 1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'hFFFF_FFFF, 8'd0,   1'b1, 32'h0000_0000, 1'b1},
            '{FUNC_READ,   32'h0000_0000, 8'd1,   1'b1, 32'hFFFF_FFFF, 1'b1},
            '{FUNC_READ,   32'h0000_0000, 8'd2,   1'b1, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'h0000_0000, 8'd255, 1'b1, 32'h0000_0000, 1'b0},
            '{FUNC_UNUSED, 32'hFFFF_FFFF, 8'd255, 1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'h0000_0000, 8'd0,   1'b1, 32'h0000_0000, 1'b1},
            '{FUNC_RECORD, 32'hA5A5_A5A5, 8'd0,   1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_RECORD, 32'h5A5A_5A5A, 8'd0,   1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'h0000_0000, 8'd0,   1'b1, 32'h5A5A_5A5A, 1'b1},
            '{FUNC_READ,   32'h0000_0000, 8'd1,   1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'h0000_0000, 8'd3,   1'b1, 32'hFFFF_FFFF, 1'b1},
            '{FUNC_READ,   32'h0000_0000, 8'd4,   1'b1, 32'h0000_0000, 1'b0},
            '{FUNC_CLEAR,  32'hFFFF_FFFF, 8'd255, 1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'h0000_0000, 8'd0,   1'b1, 32'h0000_0000, 1'b0},
            '{FUNC_CLEAR,  32'h0000_0000, 8'd0,   1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_RECORD, 32'h8000_0001, 8'd0,   1'b0, 32'h0000_0000, 1'b0},
            '{FUNC_READ,   32'h0000_0000, 8'd0,   1'b1, 32'h8000_0001, 1'b1},
            '{FUNC_READ,   32'h0000_0000, 8'd1,   1'b1, 32'h0000_0000, 1'b0},
            '{FUNC_UNUSED, 32'h0000_0000, 8'd0,   1'b0, 32'h0000_0000, 1'b0}
        };

        // Hold reset low, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            tres.pc      = dir_tbl[i].exp_pc;
            tres.present = dir_tbl[i].exp_present;
            send_txn(dir_tbl[i].func, dir_tbl[i].pc, dir_tbl[i].back, dir_tbl[i].typed, tres);
        end

        // Random traffic: mostly records and reads, rare clears, long fill runs to wrap the ring
        tres     = '0;
        fill_run = 300;
        for (int n = 0; n < RAND_TXNS; n++) begin
            if ($urandom_range(0, 49) == 0)
                no_gaps = ~no_gaps;
            r    = $urandom_range(0, 999);
            back = BACK_W'($urandom_range(0, 255));
            if (fill_run > 0) begin
                f = FUNC_RECORD;
                fill_run--;
            end else if (r < 3) begin
                f = FUNC_CLEAR;
            end else if (r < 6) begin
                f        = FUNC_RECORD;
                fill_run = $urandom_range(256, 320);
            end else if (r < 40) begin
                f = FUNC_UNUSED;
            end else if (r < 560) begin
                f = FUNC_RECORD;
            end else begin
                f    = FUNC_READ;
                held = fill_level();
                // aim the offset inside the fill, at its edge, near the newest, or leave it random
                case ($urandom_range(0, 3))
                    1: back = BACK_W'((held > 0) ? $urandom_range(0, held - 1) : 0);
                    2: begin
                        ofs  = $urandom_range(0, 2);
                        back = (held + ofs > 256) ? 8'd255 : BACK_W'(held + ofs - 1);
                    end
                    3: back = BACK_W'($urandom_range(0, 7));
                    default: ;
                endcase
            end
            send_txn(f, $urandom(), back, 1'b0, tres);
        end

        // Drain outstanding reads, then let the pipeline settle
        start <= 1'b0;
        while (pending_reads.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("covered %0d records, %0d reads (%0d hit, %0d miss), %0d clears, %0d ignored",
                 n_record, n_lookup, n_hits, n_misses, n_clear, n_ignored);
        $display("peak fill %0d of %0d, %0d reads on a full ring, %0d mismatches",
                 peak_fill, HIST_DEPTH, n_full_rd, n_errors);
        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
